[rtl/bdab_pkg.sv]
// ----------------------------------------------------------------------------
// bdab_pkg
// Shared types and constants for the button debounce / alarm blinker block.
// ----------------------------------------------------------------------------
package bdab_pkg;

  localparam int unsigned HIST_W  = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned REG_W   = 8;
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned LVL_W   = 2;

  localparam logic [HIST_W-1:0] PRESS_PATTERN = 8'hF0;
  localparam logic [HIST_W-1:0] HOLD_PATTERN  = 8'hFF;

  // register indexes on the config port
  typedef enum logic [IDX_W-1:0] {
    REG_LOW_ON      = 3'd0,
    REG_LOW_PERIOD  = 3'd1,
    REG_MED_ON      = 3'd2,
    REG_MED_PERIOD  = 3'd3,
    REG_HIGH_ON     = 3'd4,
    REG_HIGH_PERIOD = 3'd5
  } reg_idx_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_NONE = 2'd0,
    LVL_LOW  = 2'd1,
    LVL_MED  = 2'd2,
    LVL_HIGH = 2'd3
  } alarm_lvl_t;

  localparam logic [REG_W-1:0] RST_LOW_ON      = 8'd2;
  localparam logic [REG_W-1:0] RST_LOW_PERIOD  = 8'd75;
  localparam logic [REG_W-1:0] RST_MED_ON      = 8'd15;
  localparam logic [REG_W-1:0] RST_MED_PERIOD  = 8'd75;
  localparam logic [REG_W-1:0] RST_HIGH_ON     = 8'd15;
  localparam logic [REG_W-1:0] RST_HIGH_PERIOD = 8'd30;

  // what one debounce lane reports for the current word
  typedef struct packed {
    logic press;  // short press seen, history cleared
    logic hold;   // history after this word is all pressed
  } lane_stat_t;

  // blink timing picked for the current level
  typedef struct packed {
    logic             active;
    logic [REG_W-1:0] on_ticks;
    logic [REG_W-1:0] period;
  } blink_cfg_t;

endpackage

[rtl/bdab_lane.sv]
// ----------------------------------------------------------------------------
// bdab_lane
// One debounce lane: shift history of an active-low pin, short press detect.
// ----------------------------------------------------------------------------
module bdab_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                pin,
  output bdab_pkg::lane_stat_t stat
);
  import bdab_pkg::*;

  logic [HIST_W-1:0] hist_r;
  logic [HIST_W-1:0] shifted;
  logic [HIST_W-1:0] hist_nxt;

  always_comb begin
    shifted    = {hist_r[HIST_W-2:0], ~pin};
    stat.press = (shifted == PRESS_PATTERN);
    hist_nxt   = stat.press ? '0 : shifted;
    stat.hold  = (hist_nxt == HOLD_PATTERN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (en) begin
      hist_r <= hist_nxt;
    end
  end

endmodule

[rtl/bdab_blink.sv]
// ----------------------------------------------------------------------------
// bdab_blink
// Alarm LED blinker: wrapping tick counter with on-time and period compare.
// ----------------------------------------------------------------------------
module bdab_blink (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  bdab_pkg::blink_cfg_t bcfg,
  output logic                 led_nxt
);
  import bdab_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             led_r;

  always_comb begin
    cnt_nxt = '0;
    led_nxt = 1'b0;
    if (bcfg.active) begin
      led_nxt = led_r;
      if (cnt_r == '0) begin
        led_nxt = 1'b1;
      end
      // turn-off wins when on-time is zero
      if (cnt_r == bcfg.on_ticks) begin
        led_nxt = 1'b0;
      end
      cnt_nxt = (cnt_r == bcfg.period) ? '0 : cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      led_r <= 1'b0;
    end else if (en) begin
      cnt_r <= cnt_nxt;
      led_r <= led_nxt;
    end
  end

endmodule

[rtl/button_debounce_alarm_blinker.sv]
// ----------------------------------------------------------------------------
// button_debounce_alarm_blinker
// Two debounce lanes, a merge stage for the disable/valve logic and an alarm
// LED blinker; one tick word in, one status word out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tdata: mute_pin, history_pin, alarm_level
//  out_    | out | out_tvalid/tready   | tdata: mute_ev, hist_ev, disable_ev, valve, led
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled: state updates on the
//  accepting edge and the result sits in the output register on the next cycle.
//  A new word is taken whenever the output register is empty or being drained.
//  Output stall holds the result and blocks input only while it persists.
//  Synchronous active-low reset clears histories, counter, LED, valve and
//  restores the timing registers; cfg_ready is always high.
// ----------------------------------------------------------------------------
module button_debounce_alarm_blinker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [0] mute_pin, [1] history_pin, [3:2] alarm_level, [7:4] zero
  input  logic [7:0]                   in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [0] mute_event, [1] history_event, [2] disable_event, [3] valve_open,
  // [4] led_on, [7:5] zero
  output logic [7:0]                   out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bdab_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bdab_pkg::REG_W-1:0]   cfg_data
);
  import bdab_pkg::*;

  logic             acc;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             valve_r;
  logic             valve_nxt;
  logic             dis_ev;
  logic             led_nxt;
  lane_stat_t       mute_stat;
  lane_stat_t       hist_stat;
  blink_cfg_t       bcfg;
  alarm_lvl_t       lvl;

  logic [REG_W-1:0] low_on_r, low_per_r, med_on_r, med_per_r, high_on_r, high_per_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  bdab_lane u_mute_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (acc),
    .pin   (in_tdata[0]),
    .stat  (mute_stat)
  );

  bdab_lane u_hist_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (acc),
    .pin   (in_tdata[1]),
    .stat  (hist_stat)
  );

  // merge: both lanes held
  assign dis_ev    = mute_stat.hold && hist_stat.hold;
  assign valve_nxt = valve_r || dis_ev;

  always_comb begin
    lvl  = alarm_lvl_t'(in_tdata[3:2]);
    bcfg = '{active: 1'b0, on_ticks: '0, period: '0};
    unique case (lvl)
      LVL_NONE: bcfg = '{active: 1'b0, on_ticks: '0, period: '0};
      LVL_LOW:  bcfg = '{active: 1'b1, on_ticks: low_on_r,  period: low_per_r};
      LVL_MED:  bcfg = '{active: 1'b1, on_ticks: med_on_r,  period: med_per_r};
      LVL_HIGH: bcfg = '{active: 1'b1, on_ticks: high_on_r, period: high_per_r};
      default:  bcfg = '{active: 1'b0, on_ticks: '0, period: '0};
    endcase
  end

  bdab_blink u_blink (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (acc),
    .bcfg    (bcfg),
    .led_nxt (led_nxt)
  );

  // timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_on_r   <= RST_LOW_ON;
      low_per_r  <= RST_LOW_PERIOD;
      med_on_r   <= RST_MED_ON;
      med_per_r  <= RST_MED_PERIOD;
      high_on_r  <= RST_HIGH_ON;
      high_per_r <= RST_HIGH_PERIOD;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LOW_ON:      low_on_r   <= cfg_data;
        REG_LOW_PERIOD:  low_per_r  <= cfg_data;
        REG_MED_ON:      med_on_r   <= cfg_data;
        REG_MED_PERIOD:  med_per_r  <= cfg_data;
        REG_HIGH_ON:     high_on_r  <= cfg_data;
        REG_HIGH_PERIOD: high_per_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      valve_r     <= 1'b0;
    end else begin
      if (acc) begin
        out_valid_r <= 1'b1;
        valve_r     <= valve_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= {3'b000, led_nxt, valve_nxt, dis_ev, hist_stat.press, mute_stat.press};
    end
  end

endmodule

[rtl/bdab_checker.sv]
// ----------------------------------------------------------------------------
// bdab_checker
// Port-level checks for the debounce / blinker block, bound to the top level.
// ----------------------------------------------------------------------------
module bdab_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic seen_valve_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_valve_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tdata[3]) begin
      seen_valve_r <= 1'b1;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // valve never drops once delivered
  a_valve_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && seen_valve_r |-> out_tdata[3])
    else $error("valve cleared after being set");

  a_dis_valve: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[3])
    else $error("disable without valve");

  // a press clears its history, so it cannot coincide with a hold
  a_press_no_dis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1]) |-> !out_tdata[2])
    else $error("press and disable in the same word");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

endmodule

bind button_debounce_alarm_blinker bdab_checker u_bdab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[dv/tick_status_checker.sv]
// ----------------------------------------------------------------------------
// tick_status_checker
// Watches the tick, status and timing channels of the debounce / blinker
// block, predicts every status word and compares it with what comes out.
// ----------------------------------------------------------------------------
module tick_status_checker
  import bdab_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [7:0]       out_tdata,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // members MSB first so that the struct lines up with tdata[4:0]
  typedef struct packed {
    logic led_on;
    logic valve_open;
    logic disable_ev;
    logic history_ev;
    logic mute_ev;
  } tick_status_t;

  tick_status_t     expected_status_q[$];
  logic [HIST_W-1:0] mute_hist, hist_hist;
  logic [CNT_W-1:0]  blink_cnt;
  logic              led, valve;
  logic [REG_W-1:0]  timing [NUM_REGS];
  int                n_bad;

  function automatic tick_status_t advance_tick(input logic [7:0] word);
    tick_status_t     st;
    alarm_lvl_t       lvl;
    logic [REG_W-1:0] on_t, per_t;
    st = '0;
    lvl = alarm_lvl_t'(word[3:2]);
    // pins are active low
    mute_hist = {mute_hist[HIST_W-2:0], ~word[0]};
    hist_hist = {hist_hist[HIST_W-2:0], ~word[1]};
    if (mute_hist == PRESS_PATTERN) begin
      st.mute_ev = 1'b1;
      mute_hist = '0;
    end
    if (hist_hist == PRESS_PATTERN) begin
      st.history_ev = 1'b1;
      hist_hist = '0;
    end
    if (mute_hist == HOLD_PATTERN && hist_hist == HOLD_PATTERN) begin
      st.disable_ev = 1'b1;
      valve = 1'b1;
    end
    if (lvl == LVL_NONE) begin
      blink_cnt = '0;
      led = 1'b0;
    end else begin
      case (lvl)
        LVL_LOW: begin
          on_t  = timing[REG_LOW_ON];
          per_t = timing[REG_LOW_PERIOD];
        end
        LVL_MED: begin
          on_t  = timing[REG_MED_ON];
          per_t = timing[REG_MED_PERIOD];
        end
        default: begin
          on_t  = timing[REG_HIGH_ON];
          per_t = timing[REG_HIGH_PERIOD];
        end
      endcase
      // turn-off wins when the on-count is zero
      if (blink_cnt == '0) led = 1'b1;
      if (blink_cnt == on_t) led = 1'b0;
      blink_cnt = (blink_cnt == per_t) ? '0 : blink_cnt + 1'b1;
    end
    st.valve_open = valve;
    st.led_on = led;
    return st;
  endfunction

  always @(posedge clk) begin
    tick_status_t want, got;
    if (!rst_n) begin
      expected_status_q.delete();
      mute_hist = '0;
      hist_hist = '0;
      blink_cnt = '0;
      led = 1'b0;
      valve = 1'b0;
      timing[REG_LOW_ON]      = RST_LOW_ON;
      timing[REG_LOW_PERIOD]  = RST_LOW_PERIOD;
      timing[REG_MED_ON]      = RST_MED_ON;
      timing[REG_MED_PERIOD]  = RST_MED_PERIOD;
      timing[REG_HIGH_ON]     = RST_HIGH_ON;
      timing[REG_HIGH_PERIOD] = RST_HIGH_PERIOD;
      n_bad = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = tick_status_t'(out_tdata[4:0]);
        if (expected_status_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: status word %02h with nothing expected", $realtime, out_tdata);
        end else begin
          want = expected_status_q.pop_front();
          if (got.mute_ev !== want.mute_ev || got.history_ev !== want.history_ev ||
              got.disable_ev !== want.disable_ev || got.valve_open !== want.valve_open ||
              got.led_on !== want.led_on || out_tdata[7:5] !== 3'b000) begin
            n_bad++;
            // bits from the top: led, valve, disable, history, mute
            if (n_bad <= 10)
              $display("%0t: status mismatch: expected %05b got %05b pad %03b",
                       $realtime, want, got, out_tdata[7:5]);
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        timing[cfg_index] = cfg_data;
      if (in_tvalid && in_tready)
        expected_status_q.push_back(advance_tick(in_tdata));
    end
    errors  <= n_bad;
    pending <= expected_status_q.size();
  end

endmodule

[dv/button_debounce_alarm_blinker_tb.sv]
// ----------------------------------------------------------------------------
// button_debounce_alarm_blinker_tb
// Drives tick words and timing writes into the debounce / blinker block
// under varying back-pressure; the checker beside it predicts every status
// word. Directed button presses, holds and level changes come first, then
// random press, hold, bounce and noise sequences over several timing sets.
// ----------------------------------------------------------------------------
module button_debounce_alarm_blinker_tb;
  import bdab_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = 8'h03;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  int status_errors;
  int status_pending;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int random_ticks_sent = 0;

  localparam int RANDOM_TICKS = 1250;
  localparam int TIMING_SETS  = 5;

  button_debounce_alarm_blinker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tick_status_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (status_errors),
    .pending   (status_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input logic mute_pin, input logic hist_pin, input alarm_lvl_t lvl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, lvl, hist_pin, mute_pin};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending and let every status word come back
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (status_pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic load_timing(input logic [REG_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    // out-of-range index must leave the timing alone
    cfg_index <= IDX_W'($urandom_range(NUM_REGS, 2**IDX_W - 1));
    cfg_data  <= REG_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int n_ticks);
    logic [1:0] pins_q[$];
    logic [1:0] pins;
    alarm_lvl_t lvl;
    int         lvl_left;
    int         sent;
    int         len;
    lvl = LVL_LOW;
    lvl_left = 0;
    sent = 0;
    while (sent < n_ticks) begin
      // pins are {history, mute}, active low
      if (pins_q.size() == 0) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            len = $urandom_range(3, 5);
            repeat (len) pins_q.push_back(2'b10);
            repeat (4) pins_q.push_back(2'b11);
          end
          2, 3: begin
            len = $urandom_range(3, 5);
            repeat (len) pins_q.push_back(2'b01);
            repeat (4) pins_q.push_back(2'b11);
          end
          4: begin
            repeat (4) pins_q.push_back(2'b00);
            repeat (4) pins_q.push_back(2'b11);
          end
          5: begin
            len = $urandom_range(8, 14);
            repeat (len) pins_q.push_back(2'b00);
            repeat (4) pins_q.push_back(2'b11);
          end
          6, 7: begin
            len = $urandom_range(1, 8);
            repeat (len) pins_q.push_back(2'($urandom));
          end
          default: begin
            len = $urandom_range(1, 10);
            repeat (len) pins_q.push_back(2'b11);
          end
        endcase
      end
      if (lvl_left == 0) begin
        lvl = alarm_lvl_t'($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 3));
        lvl_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
                                               : $urandom_range(1, 60);
      end
      if (random_ticks_sent < RANDOM_TICKS / 3) begin
        send_idle_pct = 20;
        sink_stall_pct <= 87;
      end else if (random_ticks_sent < 2 * RANDOM_TICKS / 3) begin
        send_idle_pct = 87;
        sink_stall_pct <= 20;
      end else begin
        send_idle_pct = 0;
        sink_stall_pct <= 0;
      end
      pins = pins_q.pop_front();
      send_tick(pins[0], pins[1], lvl);
      lvl_left--;
      sent++;
      random_ticks_sent++;
    end
  endtask

  initial begin
    logic [REG_W-1:0] timing_set [NUM_REGS];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // short presses, a held pair and level changes on the reset timing
    for (int k = 0; k < 8; k++) send_tick(k >= 4, 1'b1, LVL_LOW);
    for (int k = 0; k < 8; k++) send_tick(1'b1, k >= 4, LVL_MED);
    for (int k = 0; k < 9; k++) send_tick(1'b0, 1'b0, LVL_HIGH);
    send_tick(1'b1, 1'b1, LVL_NONE);
    drain();

    for (int s = 0; s < TIMING_SETS; s++) begin
      for (int i = 0; i < NUM_REGS; i += 2) begin
        case (s)
          0: begin
            timing_set[i]   = '0;
            timing_set[i+1] = '0;
          end
          1: begin
            timing_set[i]   = '1;
            timing_set[i+1] = '1;
          end
          2: begin
            timing_set[i]   = REG_W'($urandom_range(0, 12));
            timing_set[i+1] = REG_W'($urandom_range(0, 24));
          end
          3: begin
            timing_set[i]   = REG_W'($urandom_range(0, 255));
            timing_set[i+1] = REG_W'($urandom_range(0, 255));
          end
          default: begin
            timing_set[i]   = REG_W'($urandom_range(1, 40));
            timing_set[i+1] = timing_set[i];
          end
        endcase
      end
      load_timing(timing_set);
      run_random(RANDOM_TICKS / TIMING_SETS);
      drain();
    end

    if (status_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bdab_pkg.sv
rtl/bdab_lane.sv
rtl/bdab_blink.sv
rtl/button_debounce_alarm_blinker.sv
rtl/bdab_checker.sv
dv/tick_status_checker.sv
dv/button_debounce_alarm_blinker_tb.sv
